// ===== hw/rtl/ewmn_pkg.sv =====
package ewmn_pkg;

  localparam int MAX_NEIGHBOURS = 5;
  localparam int MAX_NODES      = 64;
  localparam int ID_REGS        = 5;
  localparam int EFF_MAX        = (MAX_NEIGHBOURS < ID_REGS) ? MAX_NEIGHBOURS : ID_REGS;

  localparam int ID_W    = 6;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 3;
  localparam int SLOT_W  = $clog2(ID_REGS);
  localparam int NODE_W  = $clog2(MAX_NODES + 1) > ID_W ? $clog2(MAX_NODES + 1) : ID_W + 1;

  // pending-result vector: one bit per DOWN slot, then UP, DONE, ERR
  localparam int PEND_W    = ID_REGS + 3;
  localparam int PEND_UP   = ID_REGS;
  localparam int PEND_DONE = ID_REGS + 1;
  localparam int PEND_ERR  = ID_REGS + 2;
  localparam int PIDX_W    = $clog2(PEND_W);

  // register index codes
  localparam logic [2:0] REG_NCOUNT = 3'd0;
  localparam logic [2:0] REG_ID_A   = 3'd1;
  localparam logic [2:0] REG_ID_B   = 3'd2;
  localparam logic [2:0] REG_ID_C   = 3'd3;
  localparam logic [2:0] REG_ID_D   = 3'd4;
  localparam logic [2:0] REG_ID_E   = 3'd5;
  localparam logic [2:0] REG_INIT   = 3'd6;
  localparam logic [2:0] REG_LOCAL  = 3'd7;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_MSG   = 1'b1;

  localparam logic TAG_DOWN = 1'b0;
  localparam logic TAG_UP   = 1'b1;

  localparam logic [1:0] KIND_MSG  = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  typedef logic [ID_REGS-1:0][ID_W-1:0] id_arr_t;

  typedef struct packed {
    logic [CNT_W-1:0]        count;
    id_arr_t                 ids;
    logic                    init;
    logic signed [VAL_W-1:0] local_value;
  } cfg_t;

  typedef struct packed {
    logic [PEND_W-1:0]       pend;
    logic [ID_W-1:0]         aux_dest;
    logic signed [VAL_W-1:0] value;
  } plan_t;

endpackage

// ===== hw/rtl/ewmn_core.sv =====
module ewmn_core
  import ewmn_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    fire,
  input  logic                    command,
  input  logic [ID_W-1:0]         source_id,
  input  logic signed [VAL_W-1:0] msg_value,
  input  cfg_t                    cfg,
  output plan_t                   plan
);

  logic                    active_r, active_nxt;
  logic                    known_r, known_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [SLOT_W-1:0]       parent_r, parent_nxt;
  logic signed [VAL_W-1:0] min_r, min_nxt;

  logic [CNT_W-1:0]  n_eff;
  logic              found;
  logic [SLOT_W-1:0] slot;
  logic [ID_W-1:0]   pid;
  logic              in_range;

  always_comb begin
    n_eff = (cfg.count > CNT_W'(EFF_MAX)) ? CNT_W'(EFF_MAX) : cfg.count;
    in_range = {{(NODE_W-ID_W){1'b0}}, source_id} < NODE_W'(MAX_NODES);
    // scan downward so the lowest matching slot wins
    found = 1'b0;
    slot  = '0;
    for (int i = ID_REGS - 1; i >= 0; i--) begin
      if (CNT_W'(i) < n_eff && cfg.ids[i] == source_id && in_range) begin
        found = 1'b1;
        slot  = SLOT_W'(i);
      end
    end
    pid = cfg.ids[slot];
  end

  always_comb begin
    active_nxt = active_r;
    known_nxt  = known_r;
    count_nxt  = count_r;
    parent_nxt = parent_r;
    min_nxt    = min_r;
    plan       = '0;
    plan.value = min_r;
    if (command == CMD_START) begin
      count_nxt  = '0;
      parent_nxt = '0;
      known_nxt  = 1'b0;
      min_nxt    = cfg.local_value;
      active_nxt = 1'b1;
      plan.value = cfg.local_value;
      if (n_eff == '0) begin
        plan.pend[PEND_DONE] = 1'b1;
        active_nxt = 1'b0;
      end else if (cfg.init) begin
        for (int i = 0; i < ID_REGS; i++) begin
          plan.pend[i] = CNT_W'(i) < n_eff;
        end
      end
    end else if (active_r) begin
      if (!found) begin
        plan.pend[PEND_ERR] = 1'b1;
        plan.aux_dest       = source_id;
        active_nxt          = 1'b0;
      end else begin
        if (msg_value < min_r) begin
          min_nxt    = msg_value;
          plan.value = msg_value;
        end
        if (!cfg.init && !known_r) begin
          parent_nxt = slot;
          known_nxt  = 1'b1;
          for (int i = 0; i < ID_REGS; i++) begin
            plan.pend[i] = CNT_W'(i) < n_eff && cfg.ids[i] != pid;
          end
        end
        count_nxt = count_r + CNT_W'(1);
        if (count_nxt >= n_eff) begin
          if (!cfg.init && known_nxt) begin
            plan.pend[PEND_UP] = 1'b1;
            plan.aux_dest      = cfg.ids[parent_nxt];
          end
          plan.pend[PEND_DONE] = 1'b1;
          active_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      known_r  <= 1'b0;
      count_r  <= '0;
      parent_r <= '0;
      min_r    <= '0;
    end else if (fire) begin
      active_r <= active_nxt;
      known_r  <= known_nxt;
      count_r  <= count_nxt;
      parent_r <= parent_nxt;
      min_r    <= min_nxt;
    end
  end

endmodule

// ===== hw/rtl/ewmn_emit.sv =====
module ewmn_emit
  import ewmn_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    plan_load,
  input  plan_t                   plan,
  input  id_arr_t                 ids,
  output logic                    plan_take,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_kind,
  output logic [ID_W-1:0]         out_dest,
  output logic                    out_tag,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    out_last
);

  logic [PEND_W-1:0]       pend_r, pend_nxt;
  logic [ID_W-1:0]         aux_r;
  logic signed [VAL_W-1:0] value_r;

  logic                    valid_r;
  logic [1:0]              kind_r;
  logic [ID_W-1:0]         dest_r;
  logic                    tag_r;
  logic signed [VAL_W-1:0] oval_r;
  logic                    last_r;

  logic              pend_any;
  logic              out_load;
  logic [PIDX_W-1:0] idx;
  logic [PEND_W-1:0] pend_left;
  logic [1:0]        sel_kind;
  logic [ID_W-1:0]   sel_dest;

  always_comb begin
    pend_any = |pend_r;
    idx = '0;
    for (int i = PEND_W - 1; i >= 0; i--) begin
      if (pend_r[i]) idx = PIDX_W'(i);
    end
    pend_left = pend_r & ~(PEND_W'(1) << idx);
    out_load  = pend_any && (!valid_r || out_ready);
    plan_take = !pend_any || (out_load && pend_left == '0);

    if (idx < PIDX_W'(ID_REGS)) begin
      sel_kind = KIND_MSG;
      sel_dest = ids[SLOT_W'(idx)];
    end else if (idx == PIDX_W'(PEND_UP)) begin
      sel_kind = KIND_MSG;
      sel_dest = aux_r;
    end else if (idx == PIDX_W'(PEND_DONE)) begin
      sel_kind = KIND_DONE;
      sel_dest = '0;
    end else begin
      sel_kind = KIND_ERR;
      sel_dest = aux_r;
    end

    pend_nxt = pend_r;
    if (plan_take) begin
      pend_nxt = plan_load ? plan.pend : '0;
    end else if (out_load) begin
      pend_nxt = pend_left;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      if (out_load) begin
        valid_r <= 1'b1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (plan_take && plan_load) begin
      aux_r   <= plan.aux_dest;
      value_r <= plan.value;
    end
    if (out_load) begin
      kind_r <= sel_kind;
      dest_r <= sel_dest;
      tag_r  <= (idx == PIDX_W'(PEND_UP)) ? TAG_UP : TAG_DOWN;
      oval_r <= value_r;
      last_r <= pend_left == '0;
    end
  end

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_dest  = dest_r;
  assign out_tag   = tag_r;
  assign out_value = oval_r;
  assign out_last  = last_r;

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && kind_r == KIND_ERR |-> last_r)
    else $error("error result not last");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && kind_r == KIND_DONE |-> last_r)
    else $error("done report not last");

  a_up_then_done: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && kind_r == KIND_MSG && tag_r == TAG_UP |-> !last_r && pend_r[PEND_DONE])
    else $error("UP message not followed by done");

  a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r[PEND_ERR] |-> $onehot(pend_r))
    else $error("error pending with other results");

endmodule

// ===== hw/rtl/echo_wave_min_node_unit.sv =====
// Echo-wave minimum node: one request in, zero to five results out.
// A request is registered on input; its results are registered on output.
// Throughput: one request per cycle while out_tready is high and each yields at
// most one result; a request with more results holds the result emitter.
// Reset (rst_n low, synchronous): run idle, minimum 0, neighbour_count 1,
// other registers 0, no results pending.
module echo_wave_min_node_unit
  import ewmn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // source_id[5:0], msg_value[37:6], zero pad
  input  logic [1:0]  in_tuser,   // command[0], msg_tag[1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // dest_id[5:0], out_value[37:6], zero pad
  output logic [2:0]  out_tuser,  // kind[1:0], out_tag[2]
  output logic        out_tlast
);

  cfg_t cfg_r;

  logic                    in_valid_r;
  logic                    cmd_r;
  logic [ID_W-1:0]         src_r;
  logic signed [VAL_W-1:0] mval_r;

  logic                    fire;
  logic                    plan_take;
  plan_t                   plan;
  logic [1:0]              o_kind;
  logic [ID_W-1:0]         o_dest;
  logic                    o_tag;
  logic signed [VAL_W-1:0] o_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{count: CNT_W'(1), ids: '0, init: 1'b0, local_value: '0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NCOUNT: cfg_r.count       <= cfg_wdata[CNT_W-1:0];
        REG_ID_A:   cfg_r.ids[0]      <= cfg_wdata[ID_W-1:0];
        REG_ID_B:   cfg_r.ids[1]      <= cfg_wdata[ID_W-1:0];
        REG_ID_C:   cfg_r.ids[2]      <= cfg_wdata[ID_W-1:0];
        REG_ID_D:   cfg_r.ids[3]      <= cfg_wdata[ID_W-1:0];
        REG_ID_E:   cfg_r.ids[4]      <= cfg_wdata[ID_W-1:0];
        REG_INIT:   cfg_r.init        <= cfg_wdata[0];
        REG_LOCAL:  cfg_r.local_value <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // process the held request once the emitter can take its results
  assign fire      = in_valid_r && plan_take;
  assign in_tready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r  <= in_tuser[0];
      src_r  <= in_tdata[ID_W-1:0];
      mval_r <= in_tdata[ID_W+VAL_W-1:ID_W];
    end
  end

  ewmn_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .command   (cmd_r),
    .source_id (src_r),
    .msg_value (mval_r),
    .cfg       (cfg_r),
    .plan      (plan)
  );

  ewmn_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .plan_load (fire),
    .plan      (plan),
    .ids       (cfg_r.ids),
    .plan_take (plan_take),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (o_kind),
    .out_dest  (o_dest),
    .out_tag   (o_tag),
    .out_value (o_value),
    .out_last  (out_tlast)
  );

  assign out_tdata = {2'b00, o_value, o_dest};
  assign out_tuser = {o_tag, o_kind};

endmodule
